// ===== sv/odo_pkg.sv =====
// shared types and constants for the planar odometry integrator
package odo_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DT,
        ST_COR1,
        ST_TRIG,
        ST_MULX,
        ST_LONGX,
        ST_ADDX,
        ST_MULY,
        ST_LONGY,
        ST_ADDY,
        ST_MULR,
        ST_LONGR,
        ST_YAW,
        ST_HALF,
        ST_COR2,
        ST_QUAT,
        ST_FIN
    } odo_state_t;

    localparam int CORDIC_ROUNDS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [31:0] TICK_RESET = 32'd4295;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000029;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000003;
            5'd29:   r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/planar_dead_reckoning_odometry.sv =====
// planar dead-reckoning odometry integrator, top level
//
//  channel   dir  width  contents
//  s_        in   96     stamp[31:0] lin_vel[63:32] ang_vel[95:64]
//  m_        out  192    pos_x[47:0] pos_y[95:48] heading[127:96] quat_z[159:128]
//                        quat_w[191:160]
//  cfg_      in   32     tick_seconds write, no read-back
//
// each request runs through two 30-round passes of the cordic and the four-step partial
// products of the shared 32x32 multiplier (three long products per request).
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next request may be accepted meanwhile.
// aresetn is synchronous, clears position and heading and reloads tick_seconds.
module planar_dead_reckoning_odometry
    import odo_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // stamp, lin_vel, ang_vel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata    // pos_x, pos_y, heading, quat_z, quat_w
);

    odo_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    logic [31:0] tick_reg, tick_next;
    logic signed [47:0] x_reg, x_next, y_reg, y_next;
    logic [31:0] yaw_reg, yaw_next;
    logic [31:0] prev_reg, prev_next;
    logic seen_reg, seen_next;

    logic [31:0] lin_reg, lin_next, ang_reg, ang_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [63:0] dt_reg, dt_next;
    logic [63:0] mag_reg, mag_next;
    logic neg_reg, neg_next;
    logic [127:0] acc_reg, acc_next;

    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic flip_reg, flip_next;
    logic signed [31:0] cos_reg, cos_next, sin_reg, sin_next;

    logic m_valid_reg, m_valid_next;
    logic [191:0] m_data_reg, m_data_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [127:0] pp_shifted;
    logic [79:0] rate_lo, rate_neg;
    logic [31:0] yaw_inc, half_ang;
    logic accept, out_free;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30[31:0];
        end else if (v < -ONE_Q30) begin
            r = -(ONE_Q30[31:0]);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] pos_update(input logic signed [47:0] acc,
                                                      input logic neg,
                                                      input logic [127:0] p);
        logic signed [49:0] step;
        logic signed [49:0] acc_w;
        logic signed [49:0] r;
        logic signed [47:0] res;
        step = (p[127:101] != 27'd0) ? $signed(50'd1 << 48) : $signed({3'b000, p[100:54]});
        acc_w = {{2{acc[47]}}, acc};
        r = neg ? (acc_w - step) : (acc_w + step);
        if (r[49:47] == 3'b000 || r[49:47] == 3'b111) begin
            res = r[47:0];
        end else if (r[49]) begin
            res = {1'b1, 47'd0};
        end else begin
            res = {1'b0, {47{1'b1}}};
        end
        return res;
    endfunction

    function automatic logic cordic_flip(input logic [31:0] ang);
        logic [31:0] t;
        t = ang + QUARTER_TURN;
        return t[31];
    endfunction

    function automatic logic signed [33:0] cordic_z(input logic [31:0] ang);
        logic [31:0] a;
        a = cordic_flip(ang) ? (ang ^ 32'h8000_0000) : ang;
        return {{2{a[31]}}, a};
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign mul_p    = 64'(mul_a) * 64'(mul_b);
    assign rate_lo  = acc_reg[79:0];
    assign rate_neg = ~rate_lo + 80'd1;
    assign yaw_inc  = neg_reg ? rate_neg[79:48] : rate_lo[79:48];
    assign half_ang = {yaw_reg[31], yaw_reg[31:1]};

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    pp_shifted = {64'd0, mul_p};
            2'd3:    pp_shifted = {mul_p, 64'd0};
            default: pp_shifted = {32'd0, mul_p, 32'd0};
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_DT;
            ST_DT:    state_next = ST_COR1;
            ST_COR1:  if (cnt_reg == 5'(CORDIC_ROUNDS - 1)) state_next = ST_TRIG;
            ST_TRIG:  state_next = ST_MULX;
            ST_MULX:  state_next = ST_LONGX;
            ST_LONGX: if (cnt_reg[1:0] == 2'd3) state_next = ST_ADDX;
            ST_ADDX:  state_next = ST_MULY;
            ST_MULY:  state_next = ST_LONGY;
            ST_LONGY: if (cnt_reg[1:0] == 2'd3) state_next = ST_ADDY;
            ST_ADDY:  state_next = ST_MULR;
            ST_MULR:  state_next = ST_LONGR;
            ST_LONGR: if (cnt_reg[1:0] == 2'd3) state_next = ST_YAW;
            ST_YAW:   state_next = ST_HALF;
            ST_HALF:  state_next = ST_COR2;
            ST_COR2:  if (cnt_reg == 5'(CORDIC_ROUNDS - 1)) state_next = ST_QUAT;
            ST_QUAT:  state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        cnt_next     = (state_next != state_reg) ? 5'd0 : 5'(cnt_reg + 5'd1);
        tick_next    = cfg_we ? cfg_wdata : tick_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        yaw_next     = yaw_reg;
        prev_next    = prev_reg;
        seen_next    = seen_reg;
        lin_next     = lin_reg;
        ang_next     = ang_reg;
        ticks_next   = ticks_reg;
        dt_next      = dt_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        flip_next    = flip_reg;
        cos_next     = cos_reg;
        sin_next     = sin_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mul_a        = 32'd0;
        mul_b        = 32'd0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    lin_next   = s_tdata[63:32];
                    ang_next   = s_tdata[95:64];
                    ticks_next = seen_reg ? (s_tdata[31:0] - prev_reg) : 32'd0;
                    prev_next  = s_tdata[31:0];
                    seen_next  = 1'b1;
                    cx_next    = CORDIC_GAIN;
                    cy_next    = 34'sd0;
                    cz_next    = cordic_z(yaw_reg);
                    flip_next  = cordic_flip(yaw_reg);
                end
            end
            ST_DT: begin
                mul_a   = ticks_reg;
                mul_b   = tick_reg;
                dt_next = mul_p;
            end
            ST_COR1, ST_COR2: begin
                if (!cz_reg[33]) begin
                    cx_next = cx_reg - (cy_reg >>> cnt_reg);
                    cy_next = cy_reg + (cx_reg >>> cnt_reg);
                    cz_next = cz_reg - $signed({2'b00, atan_bam(cnt_reg)});
                end else begin
                    cx_next = cx_reg + (cy_reg >>> cnt_reg);
                    cy_next = cy_reg - (cx_reg >>> cnt_reg);
                    cz_next = cz_reg + $signed({2'b00, atan_bam(cnt_reg)});
                end
            end
            ST_TRIG, ST_QUAT: begin
                cos_next = clamp_q30(flip_reg ? -cx_reg : cx_reg);
                sin_next = clamp_q30(flip_reg ? -cy_reg : cy_reg);
            end
            ST_MULX: begin
                mul_a    = abs32(lin_reg);
                mul_b    = abs32(cos_reg);
                mag_next = mul_p;
                neg_next = lin_reg[31] ^ cos_reg[31];
                acc_next = 128'd0;
            end
            ST_MULY: begin
                mul_a    = abs32(lin_reg);
                mul_b    = abs32(sin_reg);
                mag_next = mul_p;
                neg_next = lin_reg[31] ^ sin_reg[31];
                acc_next = 128'd0;
            end
            ST_MULR: begin
                mul_a    = abs32(ang_reg);
                mul_b    = INV_TWO_PI_Q32;
                mag_next = mul_p;
                neg_next = ang_reg[31];
                acc_next = 128'd0;
            end
            ST_LONGX, ST_LONGY, ST_LONGR: begin
                mul_a    = cnt_reg[1] ? mag_reg[63:32] : mag_reg[31:0];
                mul_b    = cnt_reg[0] ? dt_reg[63:32] : dt_reg[31:0];
                acc_next = acc_reg + pp_shifted;
            end
            ST_ADDX: begin
                x_next = pos_update(x_reg, neg_reg, acc_reg);
            end
            ST_ADDY: begin
                y_next = pos_update(y_reg, neg_reg, acc_reg);
            end
            ST_YAW: begin
                yaw_next = yaw_reg + yaw_inc;
            end
            ST_HALF: begin
                cx_next   = CORDIC_GAIN;
                cy_next   = 34'sd0;
                cz_next   = cordic_z(half_ang);
                flip_next = cordic_flip(half_ang);
            end
            ST_FIN: begin
                if (out_free) begin
                    m_data_next  = {cos_reg, sin_reg, yaw_reg, y_reg, x_reg};
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 5'd0;
            tick_reg    <= TICK_RESET;
            x_reg       <= 48'sd0;
            y_reg       <= 48'sd0;
            yaw_reg     <= 32'd0;
            prev_reg    <= 32'd0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tick_reg    <= tick_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            yaw_reg     <= yaw_next;
            prev_reg    <= prev_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lin_reg    <= lin_next;
        ang_reg    <= ang_next;
        ticks_reg  <= ticks_next;
        dt_reg     <= dt_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        flip_reg   <= flip_next;
        cos_reg    <= cos_next;
        sin_reg    <= sin_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the planar odometry integrator: stream driver, monitor, pose predictor
`timescale 1ns / 100ps

module tb;
    import odo_pkg::*;

    typedef struct packed {
        logic signed [31:0] ang_vel;
        logic signed [31:0] lin_vel;
        logic [31:0]        stamp;
    } odo_request_t;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_z;
        logic signed [31:0] heading;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_x;
    } odo_pose_t;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_LO = -POS_HI - 1;
    localparam int STALL_LIMIT = 3000;
    localparam logic [0:29][31:0] ATAN_STEP = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;    // stamp, lin_vel, ang_vel
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;         // pos_x, pos_y, heading, quat_z, quat_w

    // predictor state
    logic [31:0] tick_q = TICK_RESET;
    longint      pos_x_q = 0;
    longint      pos_y_q = 0;
    logic [31:0] heading_q = '0;
    logic [31:0] last_stamp = '0;
    bit          have_stamp = 1'b0;

    odo_request_t request_q[$];
    odo_pose_t    pose_q[$];
    odo_request_t held;
    odo_pose_t    got, want;
    logic [31:0]  stamp_now = '0;
    bit           idle_on = 1'b1;
    int           gap = 0;
    int           stall = 0;
    int           idle_cycles = 0;
    int           errors = 0;

    planar_dead_reckoning_odometry dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void sin_cos(input logic [31:0] angle, output longint s,
                                    output longint c);
        longint x, y, z, dx, dy;
        logic [31:0] a, probe;
        a = angle;
        probe = a + QUARTER_TURN;
        if (probe[31]) a = a ^ HALF_TURN;
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < CORDIC_ROUNDS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_STEP[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_STEP[i]);
            end
        end
        if (probe[31]) begin
            x = -x;
            y = -y;
        end
        if (x > longint'(ONE_Q30)) x = longint'(ONE_Q30);
        if (x < -longint'(ONE_Q30)) x = -longint'(ONE_Q30);
        if (y > longint'(ONE_Q30)) y = longint'(ONE_Q30);
        if (y < -longint'(ONE_Q30)) y = -longint'(ONE_Q30);
        c = x;
        s = y;
    endfunction

    function automatic longint axis_step(input longint acc, input longint vel,
                                         input longint trig, input logic [63:0] dt);
        longint prod, r;
        logic [63:0] mag, stride;
        logic [127:0] full;
        prod = vel * trig;
        mag = (prod < 0) ? -prod : prod;
        full = {64'd0, mag} * {64'd0, dt};
        if (full[127:101] != 0) stride = 64'd1 << 48;
        else stride = full[117:54];
        if (stride > (64'd1 << 48)) stride = 64'd1 << 48;
        r = (prod < 0) ? acc - longint'(stride) : acc + longint'(stride);
        if (r > POS_HI) r = POS_HI;
        if (r < POS_LO) r = POS_LO;
        return r;
    endfunction

    function automatic odo_pose_t integrate(input odo_request_t r);
        logic [31:0] ticks, half;
        logic [63:0] dt, rate_u;
        logic [127:0] prod;
        longint s, c, rate;
        odo_pose_t p;
        ticks = have_stamp ? r.stamp - last_stamp : 32'd0;
        dt = 64'(ticks) * 64'(tick_q);
        sin_cos(heading_q, s, c);
        pos_x_q = axis_step(pos_x_q, longint'($signed(r.lin_vel)), c, dt);
        pos_y_q = axis_step(pos_y_q, longint'($signed(r.lin_vel)), s, dt);
        rate = longint'($signed(r.ang_vel)) * longint'(INV_TWO_PI_Q32);
        rate_u = rate;
        prod = {64'd0, rate_u} * {64'd0, dt};
        if (rate < 0) prod[127:64] = prod[127:64] - dt;
        heading_q = heading_q + prod[79:48];
        last_stamp = r.stamp;
        have_stamp = 1'b1;
        half = {heading_q[31], heading_q[31:1]};
        sin_cos(half, s, c);
        p.pos_x = pos_x_q[47:0];
        p.pos_y = pos_y_q[47:0];
        p.heading = heading_q;
        p.quat_z = s[31:0];
        p.quat_w = c[31:0];
        return p;
    endfunction

    function automatic logic [31:0] spread(input int top);
        logic [31:0] v;
        int k;
        k = $urandom_range(0, top);
        v = $urandom & ((32'd1 << k) - 32'd1);
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    function automatic odo_request_t make_request(input bit noisy);
        odo_request_t r;
        int k;
        if (noisy) begin
            r.stamp = $urandom;
            r.lin_vel = $urandom;
            r.ang_vel = $urandom;
        end else begin
            k = $urandom_range(0, 24);
            r.stamp = stamp_now + ($urandom & ((32'd1 << k) - 32'd1));
            r.lin_vel = spread(20);
            r.ang_vel = spread(19);
        end
        stamp_now = r.stamp;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic queue_request(input logic [31:0] stamp, input logic [31:0] lin,
                                 input logic [31:0] ang);
        odo_request_t r;
        r.stamp = stamp;
        r.lin_vel = lin;
        r.ang_vel = ang;
        stamp_now = stamp;
        request_q.push_back(r);
    endtask

    task automatic settle;
        do begin
            @(posedge aclk);
            #1;
        end while (request_q.size() != 0 || s_tvalid || pose_q.size() != 0);
    endtask

    task automatic load_tick(input logic [31:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        tick_q = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pose_q.push_back(integrate(held));
                if (idle_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 10);
            end
            if (!s_tvalid || s_tready) begin
                if (gap != 0 && idle_on) begin
                    s_tvalid <= 1'b0;
                    if (s_tready) gap = gap - 1;
                end else if (request_q.size() != 0) begin
                    held = request_q.pop_front();
                    s_tdata <= held;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pose_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request outstanding", m_tdata));
                end else begin
                    want = pose_q.pop_front();
                    got = m_tdata;
                    if (got.pos_x !== want.pos_x)
                        report_mismatch($sformatf("pos_x %h, want %h", got.pos_x, want.pos_x));
                    if (got.pos_y !== want.pos_y)
                        report_mismatch($sformatf("pos_y %h, want %h", got.pos_y, want.pos_y));
                    if (got.heading !== want.heading)
                        report_mismatch($sformatf("heading %h, want %h", got.heading,
                                                  want.heading));
                    if (got.quat_z !== want.quat_z)
                        report_mismatch($sformatf("quat_z %h, want %h", got.quat_z, want.quat_z));
                    if (got.quat_w !== want.quat_w)
                        report_mismatch($sformatf("quat_w %h, want %h", got.quat_w, want.quat_w));
                end
            end
            if (stall != 0 && idle_on) begin
                stall = stall - 1;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] tick_set;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // first request: no elapsed time, heading stays zero
        queue_request(32'h1000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        settle();
        // half a second per tick over a long interval, then a repeated stamp
        load_tick(32'h8000_0000);
        queue_request(32'h5000_0000, 32'h0000_0000, 32'h0001_0000);
        queue_request(32'h5000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        settle();
        load_tick(TICK_RESET);
        queue_request(32'h5000_1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_request(32'h5000_2000, 32'h8000_0000, 32'h8000_0000);
        queue_request(32'hFFFF_FF00, 32'h0001_0000, 32'h0000_8000);
        // stamp wrap
        queue_request(32'h0000_0100, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_request(32'h0000_0300, 32'hFFFF_FFFF, 32'h0000_0001);
        settle();
        // about one second per tick, drives position into saturation
        load_tick(32'hFFFF_FFFF);
        queue_request(32'h0000_02FF, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(32'h0000_02FE, 32'h8000_0000, 32'h0000_0000);
        queue_request(32'h0000_12FE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_request(32'h0000_22FE, 32'h0000_0000, 32'h8000_0000);
        settle();
        // zero tick length, nothing moves
        load_tick(32'h0000_0000);
        queue_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_request(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
        settle();
        load_tick(32'h0000_0001);
        queue_request(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_request(32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0000);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: tick_set = TICK_RESET;
                1: tick_set = 32'h0001_0000;
                2: tick_set = 32'hFFFF_FFFF;
                3: tick_set = 32'h0000_0001;
                4: tick_set = $urandom_range(2, 32'hFFFF_FFFE);
                default: tick_set = 32'h0010_0000;
            endcase
            load_tick(tick_set);
            idle_on = (ph != 5);
            repeat (140) request_q.push_back(make_request($urandom_range(0, 99) < 15));
        end

        settle();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
